### src/cbg_pkg.sv
// Shared types, constants and a helper function for the circuit breaker guard.
`default_nettype none

package cbg_pkg;

  // Counter and time stamp widths of the internal state.
  localparam int COUNT_WIDTH = 32;
  localparam int TIME_WIDTH  = 32;

  // Field widths of the item ports.
  localparam int FIELD_WIDTH     = 32;
  localparam int THRESH_WIDTH    = 16;
  localparam int RETRY_WIDTH     = 32;
  localparam int CFG_INDEX_WIDTH = 8;
  localparam int CFG_DATA_WIDTH  = 32;

  // Compare widths wide enough for both operands.
  localparam int CMP_T_WIDTH = (TIME_WIDTH > RETRY_WIDTH) ? TIME_WIDTH : RETRY_WIDTH;
  localparam int CMP_C_WIDTH = (COUNT_WIDTH > THRESH_WIDTH) ? COUNT_WIDTH : THRESH_WIDTH;

  // Breaker mode codes.
  localparam logic [1:0] MODE_CLOSED = 2'd0;
  localparam logic [1:0] MODE_OPEN   = 2'd1;
  localparam logic [1:0] MODE_HALF   = 2'd2;

  // Verdict codes.
  localparam logic [1:0] VERDICT_OK     = 2'd0;
  localparam logic [1:0] VERDICT_FAIL   = 2'd1;
  localparam logic [1:0] VERDICT_REJECT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_THRESHOLD = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_RETRY     = 8'd1;

  // Configuration reset values.
  localparam logic [THRESH_WIDTH-1:0] THRESHOLD_RESET = 16'd3;
  localparam logic [RETRY_WIDTH-1:0]  RETRY_RESET     = 32'd1000;

  // One request item.
  typedef struct packed {
    logic [FIELD_WIDTH-1:0] now_ms;
    logic                   call_ok;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]             verdict;
    logic [1:0]             mode_after;
    logic [FIELD_WIDTH-1:0] consecutive_failures;
    logic [FIELD_WIDTH-1:0] request_total;
    logic [FIELD_WIDTH-1:0] success_total;
    logic [FIELD_WIDTH-1:0] failure_total;
    logic [FIELD_WIDTH-1:0] trip_total;
  } out_item_t;

  // Configuration register contents.
  typedef struct packed {
    logic [THRESH_WIDTH-1:0] fail_limit;
    logic [RETRY_WIDTH-1:0]  retry_time_ms;
  } cfg_regs_t;

  // Staged request handed from the input register to the evaluation stage.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  // Saturating increment of a counter.
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

endpackage

`default_nettype wire

### src/cbg_cfg_regs.sv
// Configuration registers of the circuit breaker guard.
`default_nettype none

module cbg_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [cbg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [cbg_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  output cbg_pkg::cfg_regs_t                       cfg_regs
);

  cbg_pkg::cfg_regs_t regs_r;

  // Writes are always taken; an unknown index is ignored.
  assign cfg_ready = 1'b1;
  assign cfg_regs  = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.fail_limit    <= cbg_pkg::THRESHOLD_RESET;
      regs_r.retry_time_ms <= cbg_pkg::RETRY_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        cbg_pkg::CFG_IDX_THRESHOLD: begin
          regs_r.fail_limit <= cfg_data[cbg_pkg::THRESH_WIDTH-1:0];
        end
        cbg_pkg::CFG_IDX_RETRY: begin
          regs_r.retry_time_ms <= cfg_data[cbg_pkg::RETRY_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### src/cbg_in_reg.sv
// Input register stage that captures one request item.
`default_nettype none

module cbg_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cbg_pkg::in_item_t in_item,
  input  wire logic              advance,
  output cbg_pkg::stage_t        stage
);

  logic              stg_valid_r;
  cbg_pkg::in_item_t stg_item_r;

  // The register frees up when empty or when its item moves on this cycle.
  assign in_ready    = !stg_valid_r || advance;
  assign stage.valid = stg_valid_r;
  assign stage.item  = stg_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      stg_valid_r <= 1'b1;
    end else if (advance) begin
      stg_valid_r <= 1'b0;
    end
  end

  // Payload capture, no reset needed.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

### src/cbg_eval.sv
// Breaker state, per-request update logic and the result register.
`default_nettype none

module cbg_eval (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cbg_pkg::cfg_regs_t cfg_regs,
  input  wire cbg_pkg::stage_t    stage,
  output logic                    advance,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cbg_pkg::out_item_t      out_item
);

  localparam int CW  = cbg_pkg::COUNT_WIDTH;
  localparam int TW  = cbg_pkg::TIME_WIDTH;
  localparam int CTW = cbg_pkg::CMP_T_WIDTH;
  localparam int CCW = cbg_pkg::CMP_C_WIDTH;
  localparam int FW  = cbg_pkg::FIELD_WIDTH;

  logic [1:0]    mode_r,      mode_nxt;
  logic [CW-1:0] streak_r,    streak_nxt;
  logic [TW-1:0] last_fail_r, last_fail_nxt;
  logic [CW-1:0] req_r,       req_nxt;
  logic [CW-1:0] succ_r,      succ_nxt;
  logic [CW-1:0] fail_r,      fail_nxt;
  logic [CW-1:0] trip_r,      trip_nxt;
  logic [1:0]    verdict;

  logic               out_valid_r;
  cbg_pkg::out_item_t out_item_r;

  logic          fire;
  logic [TW-1:0] now;
  logic [TW-1:0] elapsed;
  logic          retry_due;
  logic [CW-1:0] streak_inc;
  logic          over_thresh;

  // The stage moves when the result register is empty or being emptied.
  assign advance   = !out_valid_r || out_ready;
  assign fire      = stage.valid && advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Time since the last failure, wrapping, and the threshold check.
  assign now         = TW'(stage.item.now_ms);
  assign elapsed     = now - last_fail_r;
  assign retry_due   = CTW'(elapsed) >= CTW'(cfg_regs.retry_time_ms);
  assign streak_inc  = cbg_pkg::sat_inc(streak_r);
  assign over_thresh = CCW'(streak_inc) > CCW'(cfg_regs.fail_limit);

  // Next state of the breaker for the staged request.
  always_comb begin
    mode_nxt      = mode_r;
    streak_nxt    = streak_r;
    last_fail_nxt = last_fail_r;
    req_nxt       = cbg_pkg::sat_inc(req_r);
    succ_nxt      = succ_r;
    fail_nxt      = fail_r;
    trip_nxt      = trip_r;
    verdict       = cbg_pkg::VERDICT_OK;
    case (mode_r)
      cbg_pkg::MODE_OPEN: begin
        // Rejected; once the retry time has passed the breaker moves to half open, as this result shows.
        fail_nxt = cbg_pkg::sat_inc(fail_r);
        trip_nxt = cbg_pkg::sat_inc(trip_r);
        verdict  = cbg_pkg::VERDICT_REJECT;
        if (retry_due) begin
          mode_nxt = cbg_pkg::MODE_HALF;
        end
      end
      cbg_pkg::MODE_HALF: begin
        if (stage.item.call_ok) begin
          streak_nxt = '0;
          succ_nxt   = cbg_pkg::sat_inc(succ_r);
          mode_nxt   = cbg_pkg::MODE_CLOSED;
          verdict    = cbg_pkg::VERDICT_OK;
        end else begin
          last_fail_nxt = now;
          streak_nxt    = streak_inc;
          fail_nxt      = cbg_pkg::sat_inc(fail_r);
          trip_nxt      = cbg_pkg::sat_inc(trip_r);
          mode_nxt      = cbg_pkg::MODE_OPEN;
          verdict       = cbg_pkg::VERDICT_FAIL;
        end
      end
      default: begin
        // Closed, and the unused code that behaves as closed.
        mode_nxt = cbg_pkg::MODE_CLOSED;
        if (stage.item.call_ok) begin
          streak_nxt = '0;
          succ_nxt   = cbg_pkg::sat_inc(succ_r);
          verdict    = cbg_pkg::VERDICT_OK;
        end else begin
          last_fail_nxt = now;
          streak_nxt    = streak_inc;
          fail_nxt      = cbg_pkg::sat_inc(fail_r);
          verdict       = cbg_pkg::VERDICT_FAIL;
          if (over_thresh) begin
            trip_nxt = cbg_pkg::sat_inc(trip_r);
            mode_nxt = cbg_pkg::MODE_OPEN;
          end
        end
      end
    endcase
  end

  // State registers update once per evaluated request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= cbg_pkg::MODE_CLOSED;
      streak_r    <= '0;
      last_fail_r <= '0;
      req_r       <= '0;
      succ_r      <= '0;
      fail_r      <= '0;
      trip_r      <= '0;
    end else if (fire) begin
      mode_r      <= mode_nxt;
      streak_r    <= streak_nxt;
      last_fail_r <= last_fail_nxt;
      req_r       <= req_nxt;
      succ_r      <= succ_nxt;
      fail_r      <= fail_nxt;
      trip_r      <= trip_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload, taken from the updated state.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r.verdict              <= verdict;
      out_item_r.mode_after           <= mode_nxt;
      out_item_r.consecutive_failures <= FW'(streak_nxt);
      out_item_r.request_total        <= FW'(req_nxt);
      out_item_r.success_total        <= FW'(succ_nxt);
      out_item_r.failure_total        <= FW'(fail_nxt);
      out_item_r.trip_total           <= FW'(trip_nxt);
    end
  end

endmodule

`default_nettype wire

### src/circuit_breaker_guard.sv
// Top level of the circuit breaker guard.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    in_item (now_ms, call_ok)
//   out_     output     out_valid / out_ready  out_item (verdict, mode, counters)
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each request passes from acceptance through the input register, then
// through the update logic into the result register. Without a result stall,
// one request per cycle is sustained, each seeing the state the last one left.
// Reset is synchronous and active low; it clears state and loads the default
// configuration. A stalled result register holds its item while the input
// register still takes one more request.
`default_nettype none

module circuit_breaker_guard (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire cbg_pkg::in_item_t                   in_item,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output cbg_pkg::out_item_t                       out_item,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [cbg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [cbg_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  cbg_pkg::cfg_regs_t cfg_regs;
  cbg_pkg::stage_t    stage;
  logic               advance;

  // Configuration registers.
  cbg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_regs  (cfg_regs)
  );

  // Input register.
  cbg_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .stage    (stage)
  );

  // Breaker update and result register.
  cbg_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_regs  (cfg_regs),
    .stage     (stage),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

### src/cbg_checker.sv
// Port-level checks for the circuit breaker guard and their bind.
`default_nettype none

module cbg_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire cbg_pkg::out_item_t out_item
);

  // A stalled result item holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // Reset leaves no result item pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item present after reset");

  // The input side stalls only behind a stalled result item.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result item");

  // A served success always closes the breaker and clears the streak.
  a_ok_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.verdict == cbg_pkg::VERDICT_OK |->
      out_item.mode_after == cbg_pkg::MODE_CLOSED && out_item.consecutive_failures == '0)
    else $error("success did not close the breaker");

  // A rejection leaves nonzero failure and trip totals and no more failures than requests.
  a_reject_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.verdict == cbg_pkg::VERDICT_REJECT |->
      out_item.trip_total != '0 && out_item.failure_total != '0 &&
      out_item.request_total >= out_item.failure_total)
    else $error("rejection not reflected in totals");

endmodule

bind circuit_breaker_guard cbg_checker u_cbg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire
